// ===== rtl/aes_pkg.sv =====
`default_nettype none
package aes_pkg;

  localparam int unsigned Rounds = 10;
  localparam int unsigned NumRegs = 2;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_word_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
      8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
      8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
      8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
      8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
      8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
      8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
      8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
      8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
      8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
      8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
      8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
      8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
      8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
      8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
      8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
      8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
      8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
      8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
      8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
      8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
      8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
      8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
      8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
      8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
      8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
      8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
      8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
      8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
      8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
      8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
      8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
      8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
      8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
      8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
      8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
      8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
      8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
      8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
      8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
      8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
      8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
      8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
      8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
      8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
      8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
      8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
      8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
      8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
      8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
      8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
      8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
      8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
      8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
      8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
      8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
      8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
      8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
      8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
      8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
      8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
      8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
      8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
      8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // Byte 0 sits in bits 127..120; byte 4*c+r is row r of column c.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = sbox(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/aes_key_sched.sv =====
`default_nettype none
// Registered key schedule: one round key per stage, so each stage after stage 0 holds one SubWord.
module aes_key_sched #(
  parameter int unsigned Rounds = aes_pkg::Rounds
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [127:0]         key_i,
  output logic [Rounds:0][127:0]    round_key_o
);

  logic [Rounds:0][127:0] rk_q;
  logic [Rounds:0][127:0] rk_d;
  logic [Rounds:0][7:0]   rcon;

  always_comb begin
    rcon[0] = 8'h01;
    for (int i = 1; i <= Rounds; i++) begin
      rcon[i] = aes_pkg::xtime(rcon[i - 1]);
    end
  end

  always_comb begin
    logic [31:0] t, w0, w1, w2, w3;
    rk_d[0] = key_i;
    for (int i = 1; i <= Rounds; i++) begin
      t  = rk_q[i - 1][31:0];
      t  = aes_pkg::sub_word({t[23:0], t[31:24]}) ^ {rcon[i - 1], 24'h0};
      w0 = rk_q[i - 1][127:96] ^ t;
      w1 = rk_q[i - 1][95:64] ^ w0;
      w2 = rk_q[i - 1][63:32] ^ w1;
      w3 = rk_q[i - 1][31:0] ^ w2;
      rk_d[i] = {w0, w1, w2, w3};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rk_q <= '0;
    end else begin
      rk_q <= rk_d;
    end
  end

  assign round_key_o = rk_q;

endmodule
`default_nettype wire

// ===== rtl/aes_round.sv =====
`default_nettype none
// One registered cipher round.
module aes_round (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  input  wire logic         last_i,
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] key_i,
  output logic              valid_o,
  output logic [127:0]      state_o
);

  logic         valid_q;
  logic [127:0] state_q;
  logic [127:0] state_d;
  logic [127:0] shifted;

  assign shifted = aes_pkg::sub_shift(state_i);
  assign state_d = (last_i ? shifted : aes_pkg::mix_columns(shifted)) ^ key_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule
`default_nettype wire

// ===== rtl/aes128_block_encrypt.sv =====
`default_nettype none
// An accepted word is registered in stage 0, then in each round register, before done_o.
// Throughput: one word per cycle while busy is low; the receiver never stalls done_o.
// busy is registered from each accepted key write and blocks start, so the next word sees the new key.
// Reset clears the key registers, the key schedule, busy and all stage valid bits.
module aes128_block_encrypt #(
  parameter int unsigned Rounds = aes_pkg::Rounds
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire aes_pkg::in_word_t data_i,
  output logic                   done_o,
  output aes_pkg::out_word_t     data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [0:0]        cfg_idx_i,
  input  wire logic [63:0]       cfg_data_i
);

  logic [63:0] key_high_q, key_low_q;
  logic [Rounds:0][127:0] round_key;
  logic [Rounds:0]        valid;
  logic [Rounds:0][127:0] state;
  logic                   busy_q;

  assign busy = busy_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= cfg_valid_i & cfg_ready_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_valid_i) begin
      case (aes_pkg::reg_idx_e'(cfg_idx_i))
        aes_pkg::REG_KEY_HIGH: key_high_q <= cfg_data_i;
        aes_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aes_key_sched #(.Rounds(Rounds)) u_key (
    .clk_i, .rst_ni,
    .key_i({key_high_q, key_low_q}),
    .round_key_o(round_key)
  );

  logic         valid0_q;
  logic [127:0] state0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else begin
      valid0_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      state0_q <= {data_i.plain_high, data_i.plain_low} ^ round_key[0];
    end
  end

  assign valid[0] = valid0_q;
  assign state[0] = state0_q;

  for (genvar g = 1; g <= Rounds; g++) begin : g_round
    aes_round u_round (
      .clk_i, .rst_ni,
      .valid_i(valid[g - 1]),
      .last_i (g == Rounds),
      .state_i(state[g - 1]),
      .key_i  (round_key[g]),
      .valid_o(valid[g]),
      .state_o(state[g])
    );
  end

  assign done_o = valid[Rounds];
  assign data_o = {state[Rounds][127:64], state[Rounds][63:0]};

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(Rounds + 1) done_o) else $error("lost word");
  a_busy_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> busy) else $error("no busy after key write");
  a_stage_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid[0] |=> valid[1]) else $error("stage valid lost");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;

  localparam int Settle = aes_pkg::Rounds + 5;
  localparam int StallLimit = 4000;

  typedef enum logic {OP_BLOCK, OP_KEY} op_e;

  typedef struct {
    op_e               op;
    aes_pkg::reg_idx_e idx;
    logic [63:0]       val;
    aes_pkg::in_word_t blk;
  } job_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  aes_pkg::in_word_t  data_i = '0;
  logic               done_o;
  aes_pkg::out_word_t data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [0:0]         cfg_idx_i = '0;
  logic [63:0]        cfg_data_i = '0;

  job_t               pending_q[$];
  aes_pkg::out_word_t cipher_q[$];
  logic [7:0]  sb[256];
  logic [31:0] rk[44];
  logic [63:0] key_hi, key_lo;
  int          errors = 0;
  int          quiet = 0;
  int          stall = 0;
  int          launched = 0;
  logic        blk_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  logic        key_fresh = 1'b0;

  aes128_block_encrypt dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .data_i     (data_i),
    .done_o     (done_o),
    .data_o     (data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = dbl(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic void build_sbox();
    logic [7:0] inv;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gf_mul(inv, a[7:0]);
      sb[a] = inv ^ rotl(inv, 1) ^ rotl(inv, 2) ^ rotl(inv, 3) ^ rotl(inv, 4) ^ 8'h63;
    end
  endfunction

  function automatic void expand_key();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    rk[0] = key_hi[63:32];
    rk[1] = key_hi[31:0];
    rk[2] = key_lo[63:32];
    rk[3] = key_lo[31:0];
    for (int i = 4; i < 44; i++) begin
      t = rk[i - 1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sb[t[31:24]] ^ rc, sb[t[23:16]], sb[t[15:8]], sb[t[7:0]]};
        rc = dbl(rc);
      end
      rk[i] = rk[i - 4] ^ t;
    end
  endfunction

  function automatic aes_pkg::out_word_t encrypt_block(input aes_pkg::in_word_t b);
    logic [7:0]   s[16];
    logic [7:0]   t[16];
    logic [7:0]   all;
    logic [127:0] v;
    v = b;
    for (int i = 0; i < 16; i++) s[i] = v[127 - 8 * i -: 8];
    for (int rnd = 0; rnd <= aes_pkg::Rounds; rnd++) begin
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[4 * c + r] = sb[s[4 * ((c + r) % 4) + r]];
        s = t;
      end
      if (rnd > 0 && rnd < aes_pkg::Rounds) begin
        for (int c = 0; c < 4; c++) begin
          all = s[4 * c] ^ s[4 * c + 1] ^ s[4 * c + 2] ^ s[4 * c + 3];
          for (int r = 0; r < 4; r++)
            t[4 * c + r] = s[4 * c + r] ^ all ^ dbl(s[4 * c + r] ^ s[4 * c + (r + 1) % 4]);
        end
        s = t;
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) s[4 * c + r] ^= rk[4 * rnd + c][31 - 8 * r -: 8];
    end
    for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = s[i];
    return aes_pkg::out_word_t'(v);
  endfunction

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h", field, got, want);
    errors++;
  endtask

  task automatic add_block(input logic [63:0] hi, input logic [63:0] lo);
    job_t j;
    j.op = OP_BLOCK;
    j.idx = aes_pkg::REG_KEY_HIGH;
    j.val = '0;
    j.blk.plain_high = hi;
    j.blk.plain_low = lo;
    pending_q.push_back(j);
  endtask

  task automatic add_key(input aes_pkg::reg_idx_e idx, input logic [63:0] val);
    job_t j;
    j.op = OP_KEY;
    j.idx = idx;
    j.val = val;
    j.blk = '0;
    pending_q.push_back(j);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Monitor and predictor.
  always @(posedge clk_i) begin
    aes_pkg::out_word_t want;
    logic               act;
    logic               blk_now;
    logic               cfg_now;
    act = 1'b0;
    blk_now = 1'b0;
    cfg_now = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        cipher_q.push_back(encrypt_block(data_i));
        blk_now = 1'b1;
        act = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (aes_pkg::reg_idx_e'(cfg_idx_i) == aes_pkg::REG_KEY_HIGH) key_hi = cfg_data_i;
        else key_lo = cfg_data_i;
        expand_key();
        cfg_now = 1'b1;
        key_fresh <= 1'b1;
        act = 1'b1;
      end
      if (done_o) begin
        act = 1'b1;
        if (cipher_q.size() == 0) begin
          report("unexpected cipher_high", data_o.cipher_high, '0);
        end else begin
          want = cipher_q.pop_front();
          if (data_o.cipher_high !== want.cipher_high)
            report("cipher_high", data_o.cipher_high, want.cipher_high);
          if (data_o.cipher_low !== want.cipher_low)
            report("cipher_low", data_o.cipher_low, want.cipher_low);
        end
      end
      quiet <= act ? 0 : quiet + 1;
      stall <= act ? 0 : stall + 1;
      if (stall >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
    blk_taken <= blk_now;
    cfg_taken <= cfg_now;
  end

  // Driver.
  always @(negedge clk_i) begin
    logic nxt_start, nxt_cfg, idle_on;
    job_t j;
    nxt_start = start;
    nxt_cfg = cfg_valid_i;
    if (rst_ni) begin
      if (blk_taken) nxt_start = 1'b0;
      if (cfg_taken) nxt_cfg = 1'b0;
      if (!nxt_start && !nxt_cfg && pending_q.size() > 0) begin
        idle_on = !(launched >= 800 && launched < 1100);
        if (pending_q[0].op == OP_KEY) begin
          if (cipher_q.size() == 0 && !start && quiet >= Settle && !cfg_taken) begin
            j = pending_q.pop_front();
            cfg_idx_i <= j.idx;
            cfg_data_i <= j.val;
            nxt_cfg = 1'b1;
          end
        end else if ((!key_fresh || quiet >= Settle) && !cfg_taken &&
                     !(idle_on && $urandom_range(99) < 21)) begin
          j = pending_q.pop_front();
          data_i <= j.blk;
          nxt_start = 1'b1;
          key_fresh <= 1'b0;
          launched++;
        end
      end
    end
    start <= nxt_start;
    cfg_valid_i <= nxt_cfg;
  end

  initial begin
    build_sbox();
    key_hi = '0;
    key_lo = '0;
    expand_key();

    add_block('0, '0);
    add_block('1, '1);
    add_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    add_key(aes_pkg::REG_KEY_HIGH, 64'h0001_0203_0405_0607);
    add_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    add_key(aes_pkg::REG_KEY_LOW, 64'h0809_0a0b_0c0d_0e0f);
    add_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    add_block('0, '0);
    add_block('1, '1);
    add_key(aes_pkg::REG_KEY_HIGH, '1);
    add_key(aes_pkg::REG_KEY_LOW, '1);
    add_block('0, '0);
    add_block('1, '1);
    add_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    add_key(aes_pkg::REG_KEY_LOW, '0);
    add_block('1, '0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          add_key(aes_pkg::REG_KEY_HIGH, '0);
          add_key(aes_pkg::REG_KEY_LOW, '0);
        end
        7: begin
          add_key(aes_pkg::REG_KEY_HIGH, '1);
          add_key(aes_pkg::REG_KEY_LOW, '1);
        end
        default: begin
          if ($urandom_range(3) != 0) add_key(aes_pkg::REG_KEY_HIGH, rand64());
          add_key(aes_pkg::REG_KEY_LOW, rand64());
        end
      endcase
      for (int k = 0; k < 230; k++) begin
        if ($urandom_range(19) == 0)
          add_block(64'h1 << $urandom_range(63), 64'h1 << $urandom_range(63));
        else
          add_block(rand64(), rand64());
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() > 0 || start || cfg_valid_i || cipher_q.size() > 0)
      @(posedge clk_i);
    repeat (aes_pkg::Rounds + 10) @(posedge clk_i);

    if (errors == 0 && cipher_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/aes_pkg.sv
rtl/aes_key_sched.sv
rtl/aes_round.sv
rtl/aes128_block_encrypt.sv
tb/tb.sv
